// ----- rtl/wsb_pkg.sv -----
// Shared types and constants for the work-stealing balancer.
// Has no dependencies; every other file of the block imports it.
package wsb_pkg;

  // Fixed widths of the report and result fields.
  localparam int DATA_W    = 24;
  localparam int CMD_W     = 3;
  localparam int WORKER_W  = 4;
  localparam int QTY_W     = 11;
  localparam int NW_W      = 5;
  localparam int TAG_W     = 3;
  localparam int CFG_IDX_W = 1;

  // Worker tags; the report kinds use the same codes.
  localparam logic [TAG_W-1:0] TAG_OVER     = 3'd0;
  localparam logic [TAG_W-1:0] TAG_STABLE   = 3'd1;
  localparam logic [TAG_W-1:0] TAG_UNDER    = 3'd2;
  localparam logic [TAG_W-1:0] TAG_IDLE     = 3'd3;
  localparam logic [TAG_W-1:0] TAG_UNLOCKED = 3'd4;
  localparam logic [TAG_W-1:0] TAG_LOCKED   = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM   = 1'b1;

  localparam logic [DATA_W-1:0] CHUNK_RST = 24'd1024;
  localparam logic [NW_W-1:0]   NW_RST    = 5'd16;

  // The initial threshold is 40 percent of the chunk size, taken as 2/5.
  localparam int THR_NUM = 2;
  localparam int THR_DEN = 5;

  typedef struct packed {
    logic clear;
    logic st_we;
    logic ct_we;
  } tbl_ctl_t;

endpackage

// ----- rtl/wsb_table.sv -----
// Per-worker tag and count tables with registered read and per-entry valid bits.
// Depends on wsb_pkg for the tag codes and the control struct.
module wsb_table import wsb_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int CNT_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_ctl_t         ctl_i,
  input  logic [CNT_W-1:0] fill_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [TAG_W-1:0] wr_status_i,
  input  logic [CNT_W-1:0] wr_count_i,
  output logic [TAG_W-1:0] rd_status_o,
  output logic [CNT_W-1:0] rd_count_o
);

  logic [TAG_W-1:0] st_mem [DEPTH];
  logic [CNT_W-1:0] ct_mem [DEPTH];
  logic [DEPTH-1:0] st_vld_q;
  logic [DEPTH-1:0] ct_vld_q;
  logic [TAG_W-1:0] rd_status_q;
  logic [CNT_W-1:0] rd_count_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.st_we) begin
      st_mem[wr_addr_i] <= wr_status_i;
    end
    if (ctl_i.ct_we) begin
      ct_mem[wr_addr_i] <= wr_count_i;
    end
    // An entry never written since the last restart reads as its reset value.
    rd_status_q <= st_vld_q[rd_addr_i] ? st_mem[rd_addr_i] : TAG_STABLE;
    rd_count_q  <= ct_vld_q[rd_addr_i] ? ct_mem[rd_addr_i] : fill_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
      ct_vld_q <= '0;
    end else if (ctl_i.clear) begin
      st_vld_q <= '0;
      ct_vld_q <= '0;
    end else begin
      if (ctl_i.st_we) begin
        st_vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.ct_we) begin
        ct_vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_status_o = rd_status_q;
  assign rd_count_o  = rd_count_q;

endmodule

// ----- rtl/wsb_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the average and threshold.
// Depends on wsb_pkg only through the common import.
module wsb_div import wsb_pkg::*; #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DVD_W-1:0] dq_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W-1:0] rem_nx;
  logic             q_bit;

  always_comb begin
    rem_sh = {rem_q, dq_q[DVD_W-1]};
    q_bit  = rem_sh >= {1'b0, dvs_q};
    rem_nx = q_bit ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DVD_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      dq_q  <= {dq_q[DVD_W-2:0], q_bit};
      rem_q <= rem_nx;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

// ----- rtl/work_stealing_balancer.sv -----
// Work-stealing balancer: one status report in, one result strobe out.
// A report that steals passes the check, the n-entry table walk, the bit-serial divider,
// the distance and quantity steps and the locking of victim and target before its strobe;
// dropped and unlock reports go from the check to the strobe. busy falls in the cycle after
// the strobe. Reset and every configuration write restart all state; a write then keeps busy
// high while the divider works out the threshold.
module work_stealing_balancer import wsb_pkg::*; #(
  parameter int MAX_WORKERS = 16,
  parameter int COUNT_BITS  = 24,
  parameter int STEAL_LIMIT = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [WORKER_W-1:0]  worker_i,
  input  logic [DATA_W-1:0]    count_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  output logic                 result_valid_o,
  output logic [DATA_W-1:0]    average_o,
  output logic [DATA_W-1:0]    threshold_o,
  output logic                 steal_o,
  output logic [WORKER_W-1:0]  victim_o,
  output logic [WORKER_W-1:0]  target_o,
  output logic [QTY_W-1:0]     quantity_o,
  output logic                 threshold_changed_o,
  output logic                 broadcast_average_o,
  output logic                 ignored_o,
  output logic                 done_res_o
);

  localparam int IDX_W  = $clog2(MAX_WORKERS);
  localparam int NUM_W  = $clog2(MAX_WORKERS + 1);
  localparam int SUM_W  = COUNT_BITS + IDX_W;
  localparam int DVS_W  = (NUM_W > 3) ? NUM_W : 3;
  localparam int NCMP_W = (NUM_W > WORKER_W) ? NUM_W : WORKER_W;
  localparam int DIST_W = COUNT_BITS + 1;
  localparam int QCMP_W = (DIST_W > 17) ? DIST_W : 17;

  localparam logic [63:0] CntMask   = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [63:0] ChunkRstC = 64'(CHUNK_RST) & CntMask;
  localparam logic [63:0] ThrRst    = ChunkRstC * 64'(THR_NUM) / 64'(THR_DEN);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_WALK      = 4'd2;
  localparam logic [3:0] S_DIV       = 4'd3;
  localparam logic [3:0] S_DIST      = 4'd4;
  localparam logic [3:0] S_QTY       = 4'd5;
  localparam logic [3:0] S_LOCK_V    = 4'd6;
  localparam logic [3:0] S_LOCK_T    = 4'd7;
  localparam logic [3:0] S_OUT       = 4'd8;
  localparam logic [3:0] S_INIT      = 4'd9;
  localparam logic [3:0] S_INIT_WAIT = 4'd10;

  logic [3:0]            state_q;
  logic [CMD_W-1:0]      cmd_q;
  logic [WORKER_W-1:0]   w_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [DATA_W-1:0]     chunk_q;
  logic [NW_W-1:0]       nw_q;
  logic [COUNT_BITS-1:0] avg_q;
  logic [COUNT_BITS-1:0] thr_q;
  logic [IDX_W-1:0]      prev_v_q;
  logic [IDX_W-1:0]      prev_t_q;
  logic                  finished_q;

  logic                  steal_q;
  logic [IDX_W-1:0]      victim_q;
  logic [IDX_W-1:0]      target_q;
  logic [QTY_W-1:0]      qty_q;
  logic                  changed_q;
  logic                  bcast_q;
  logic                  ignored_q;

  logic [NUM_W-1:0]      rd_idx_q;
  logic                  proc_vld_q;
  logic [IDX_W-1:0]      proc_idx_q;
  logic [SUM_W-1:0]      sum_q;
  logic                  idle_f_q, under_f_q, over_f_q;
  logic [IDX_W-1:0]      idle_k_q, under_k_q, over_k_q;
  logic [COUNT_BITS-1:0] idle_c_q, under_c_q, over_c_q;
  logic [COUNT_BITS-1:0] dist_a_q, dist_b_q;

  logic [NUM_W-1:0]      n_c;
  logic [COUNT_BITS-1:0] chunk_cnt;
  logic [DATA_W-1:0]     chunk_new;
  logic [IDX_W-1:0]      w_idx;
  logic                  chk_ign, chk_unlock, chk_locked, chk_go;
  logic                  walk_issue, walk_done, e_other;

  tbl_ctl_t              tbl_ctl;
  logic [IDX_W-1:0]      tbl_rd_addr, tbl_wr_addr;
  logic [TAG_W-1:0]      tbl_wr_status, tbl_rd_status;
  logic [COUNT_BITS-1:0] tbl_rd_count;

  logic                  div_start, div_done;
  logic [SUM_W-1:0]      div_dividend, div_quot;
  logic [DVS_W-1:0]      div_divisor;

  logic                  pair_steal;
  logic [IDX_W-1:0]      pair_v, pair_t;
  logic [COUNT_BITS-1:0] pair_cv, pair_ct;
  logic [DIST_W-1:0]     qsum, qhalf;
  logic [QCMP_W-1:0]     qcap;
  logic [DIST_W-1:0]     thr_dbl;
  logic                  pair_repeat;

  // Number of active workers, clamped to 1..MAX_WORKERS.
  always_comb begin
    if (nw_q == '0) begin
      n_c = NUM_W'(1);
    end else if (int'(nw_q) > MAX_WORKERS) begin
      n_c = NUM_W'(MAX_WORKERS);
    end else begin
      n_c = NUM_W'(nw_q);
    end
  end

  assign chunk_cnt = COUNT_BITS'(chunk_q);
  assign chunk_new = (cfg_idx_i == CFG_CHUNK) ? cfg_wdata_i : chunk_q;
  assign w_idx     = IDX_W'(w_q);

  always_comb begin
    chk_ign    = finished_q || (NCMP_W'(w_q) >= NCMP_W'(n_c)) || (cmd_q > TAG_UNLOCKED);
    chk_unlock = !chk_ign && (cmd_q == TAG_UNLOCKED);
    chk_locked = !chk_ign && !chk_unlock && (tbl_rd_status == TAG_LOCKED);
    chk_go     = !chk_ign && !chk_unlock && !chk_locked;
  end

  assign walk_issue = rd_idx_q < n_c;
  assign walk_done  = !walk_issue && !proc_vld_q;
  assign e_other    = proc_idx_q != w_idx;

  // Table port control.
  always_comb begin
    tbl_ctl.clear = cfg_we_i;
    tbl_ctl.st_we = 1'b0;
    tbl_ctl.ct_we = 1'b0;
    tbl_wr_addr   = w_idx;
    tbl_wr_status = chk_unlock ? TAG_UNLOCKED : cmd_q;
    case (state_q)
      S_IDLE:  tbl_rd_addr = IDX_W'(worker_i);
      S_WALK:  tbl_rd_addr = rd_idx_q[IDX_W-1:0];
      default: tbl_rd_addr = w_idx;
    endcase
    case (state_q)
      S_CHECK: begin
        tbl_ctl.st_we = chk_unlock || chk_go;
        tbl_ctl.ct_we = chk_unlock || chk_go;
      end
      S_LOCK_V: begin
        tbl_ctl.st_we = 1'b1;
        tbl_wr_addr   = victim_q;
        tbl_wr_status = TAG_LOCKED;
      end
      S_LOCK_T: begin
        tbl_ctl.st_we = 1'b1;
        tbl_wr_addr   = target_q;
        tbl_wr_status = TAG_LOCKED;
      end
      default: begin
      end
    endcase
  end

  // The divider serves the average and, after a configuration write, chunk_size * 2 / 5.
  always_comb begin
    div_start    = (state_q == S_INIT) || ((state_q == S_WALK) && walk_done);
    div_dividend = (state_q == S_INIT) ? (SUM_W'(chunk_cnt) << 1) : sum_q;
    div_divisor  = (state_q == S_INIT) ? DVS_W'(THR_DEN) : DVS_W'(n_c);
  end

  // Pairing once the new average is known.
  always_comb begin
    pair_steal = 1'b0;
    pair_v     = w_idx;
    pair_t     = w_idx;
    pair_cv    = cnt_q;
    pair_ct    = cnt_q;
    if (cmd_q == TAG_OVER) begin
      if (idle_f_q) begin
        pair_steal = 1'b1;
        pair_t     = idle_k_q;
        pair_ct    = idle_c_q;
      end else if (under_f_q) begin
        pair_steal = 1'b1;
        pair_t     = under_k_q;
        pair_ct    = under_c_q;
      end
    end else if (cmd_q inside {TAG_UNDER, TAG_IDLE}) begin
      if (over_f_q) begin
        pair_steal = 1'b1;
        pair_v     = over_k_q;
        pair_cv    = over_c_q;
      end
    end
  end

  always_comb begin
    qsum  = DIST_W'(dist_a_q) + DIST_W'(dist_b_q);
    qhalf = qsum >> 1;
    if (QCMP_W'(qhalf) > QCMP_W'(STEAL_LIMIT)) begin
      qcap = QCMP_W'(STEAL_LIMIT);
    end else begin
      qcap = QCMP_W'(qhalf);
    end
    thr_dbl     = {thr_q, 1'b0};
    pair_repeat = ((victim_q == prev_v_q) && (target_q == prev_t_q)) ||
                  ((victim_q == prev_t_q) && (target_q == prev_v_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      chunk_q    <= CHUNK_RST;
      nw_q       <= NW_RST;
      avg_q      <= COUNT_BITS'(ChunkRstC);
      thr_q      <= COUNT_BITS'(ThrRst);
      prev_v_q   <= '0;
      prev_t_q   <= '0;
      finished_q <= 1'b0;
      rd_idx_q   <= '0;
      proc_vld_q <= 1'b0;
      idle_f_q   <= 1'b0;
      under_f_q  <= 1'b0;
      over_f_q   <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_CHUNK) begin
        chunk_q <= cfg_wdata_i;
      end else begin
        nw_q <= cfg_wdata_i[NW_W-1:0];
      end
      avg_q      <= COUNT_BITS'(chunk_new);
      prev_v_q   <= '0;
      prev_t_q   <= '0;
      finished_q <= 1'b0;
      state_q    <= S_INIT;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start) begin
            cmd_q     <= cmd_i;
            w_q       <= worker_i;
            cnt_q     <= COUNT_BITS'(count_i);
            steal_q   <= 1'b0;
            victim_q  <= '0;
            target_q  <= '0;
            qty_q     <= '0;
            changed_q <= 1'b0;
            bcast_q   <= 1'b0;
            ignored_q <= 1'b0;
            state_q   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (chk_ign || chk_locked) begin
            ignored_q <= 1'b1;
            state_q   <= S_OUT;
          end else if (chk_unlock) begin
            state_q <= S_OUT;
          end else begin
            if (cmd_q == TAG_IDLE) begin
              bcast_q <= 1'b1;
              if ((thr_q >> 1) != '0) begin
                thr_q     <= thr_q >> 1;
                changed_q <= 1'b1;
              end
            end
            rd_idx_q   <= '0;
            proc_vld_q <= 1'b0;
            sum_q      <= '0;
            idle_f_q   <= 1'b0;
            under_f_q  <= 1'b0;
            over_f_q   <= 1'b0;
            state_q    <= S_WALK;
          end
        end
        S_WALK: begin
          // Read of one entry overlaps the sum and search over the previous one.
          proc_vld_q <= walk_issue;
          proc_idx_q <= rd_idx_q[IDX_W-1:0];
          if (walk_issue) begin
            rd_idx_q <= rd_idx_q + NUM_W'(1);
          end
          if (proc_vld_q) begin
            sum_q <= sum_q + SUM_W'(tbl_rd_count);
            if (e_other && !idle_f_q && (tbl_rd_status == TAG_IDLE)) begin
              idle_f_q <= 1'b1;
              idle_k_q <= proc_idx_q;
              idle_c_q <= tbl_rd_count;
            end
            if (e_other && !under_f_q && (tbl_rd_status == TAG_UNDER)) begin
              under_f_q <= 1'b1;
              under_k_q <= proc_idx_q;
              under_c_q <= tbl_rd_count;
            end
            if (e_other && !over_f_q && (tbl_rd_status == TAG_OVER)) begin
              over_f_q <= 1'b1;
              over_k_q <= proc_idx_q;
              over_c_q <= tbl_rd_count;
            end
          end
          if (walk_done) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            avg_q <= COUNT_BITS'(div_quot);
            if (sum_q == '0) begin
              finished_q <= 1'b1;
            end
            state_q <= S_DIST;
          end
        end
        S_DIST: begin
          steal_q  <= pair_steal;
          dist_a_q <= (avg_q >= pair_ct) ? (avg_q - pair_ct) : (pair_ct - avg_q);
          dist_b_q <= (avg_q >= pair_cv) ? (avg_q - pair_cv) : (pair_cv - avg_q);
          if (pair_steal) begin
            victim_q <= pair_v;
            target_q <= pair_t;
            state_q  <= S_QTY;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_QTY: begin
          qty_q <= QTY_W'(qcap);
          if (pair_repeat) begin
            thr_q     <= thr_dbl[COUNT_BITS] ? '1 : thr_dbl[COUNT_BITS-1:0];
            changed_q <= 1'b1;
          end
          prev_v_q <= victim_q;
          prev_t_q <= target_q;
          state_q  <= S_LOCK_V;
        end
        S_LOCK_V: state_q <= S_LOCK_T;
        S_LOCK_T: state_q <= S_OUT;
        S_OUT:    state_q <= S_IDLE;
        S_INIT:   state_q <= S_INIT_WAIT;
        S_INIT_WAIT: begin
          if (div_done) begin
            thr_q   <= COUNT_BITS'(div_quot);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  wsb_table #(
    .DEPTH (MAX_WORKERS),
    .IDX_W (IDX_W),
    .CNT_W (COUNT_BITS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (tbl_ctl),
    .fill_i      (chunk_cnt),
    .rd_addr_i   (tbl_rd_addr),
    .wr_addr_i   (tbl_wr_addr),
    .wr_status_i (tbl_wr_status),
    .wr_count_i  (cnt_q),
    .rd_status_o (tbl_rd_status),
    .rd_count_o  (tbl_rd_count)
  );

  wsb_div #(
    .DVD_W (SUM_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign busy                = state_q != S_IDLE;
  assign result_valid_o      = state_q == S_OUT;
  assign average_o           = DATA_W'(avg_q);
  assign threshold_o         = DATA_W'(thr_q);
  assign steal_o             = steal_q;
  assign victim_o            = WORKER_W'(victim_q);
  assign target_o            = WORKER_W'(target_q);
  assign quantity_o          = qty_q;
  assign threshold_changed_o = changed_q;
  assign broadcast_average_o = bcast_q;
  assign ignored_o           = ignored_q;
  assign done_res_o          = finished_q;

  // A result is shown for one cycle only.
  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A steal never pairs a worker with itself.
  a_pair_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && steal_o) |-> (victim_q != target_q))
    else $error("steal pair names the same worker twice");

  // Completion sticks until a configuration write restarts the block.
  a_finished_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finished_q && !cfg_we_i) |=> finished_q)
    else $error("done flag cleared without a restart");

endmodule
